@@ rtl/dtoc_pkg.sv @@
// shared constants, register codes and types for the definite-time overcurrent element
package dtoc_pkg;

    localparam int SAMPLE_WIDTH  = 24;
    localparam int COUNT_WIDTH   = 24;
    localparam int RATIO_WIDTH   = 16;
    localparam int RATIO_FRAC    = 15;
    localparam int WINDOW_HOLD   = 50;
    localparam int WCOUNT_WIDTH  = 6;
    localparam int SCALED_WIDTH  = SAMPLE_WIDTH + 4;
    localparam int PRODUCT_WIDTH = SAMPLE_WIDTH + RATIO_WIDTH;
    localparam int QUEUE_DEPTH   = 2;
    localparam int ADDR_WIDTH    = 5;

    typedef enum logic [2:0] {
        REG_PICKUP_LEVEL    = 3'd0,
        REG_DROPOUT_RATIO   = 3'd1,
        REG_DROPOUT_SAMPLES = 3'd2,
        REG_TRIP_DELAY      = 3'd3,
        REG_NOMINAL_CURRENT = 3'd4,
        REG_WINDOW_MODE     = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] pickup_level;
        logic [RATIO_WIDTH-1:0]  reset_ratio;
        logic [COUNT_WIDTH-1:0]  dropout_samples;
        logic [COUNT_WIDTH-1:0]  trip_delay_samples;
        logic [SAMPLE_WIDTH-1:0] nominal_current;
        logic                    window_mode;
    } cfg_t;

    // per-sample classification handed from front to back
    typedef struct packed {
        logic enable;
        logic in_window;
        logic above_level;
        logic below_dropout;
    } class_t;

endpackage

@@ rtl/dtoc_front.sv @@
// front end: accepts samples and classifies them against the thresholds
module dtoc_front import dtoc_pkg::*; (
    input  logic [SAMPLE_WIDTH-1:0] rms_sample,
    input  logic                    step_enable,
    input  cfg_t                    cfg,
    output class_t                  cls
);

    logic [SCALED_WIDTH-1:0]  rms_x10;
    logic [SCALED_WIDTH-1:0]  inom_x10;
    logic [PRODUCT_WIDTH-1:0] dropout_thr;
    logic [PRODUCT_WIDTH-1:0] rms_scaled;

    // times ten as x8 + x2
    assign rms_x10  = {1'b0, rms_sample, 3'b000} + {3'b000, rms_sample, 1'b0};
    assign inom_x10 = {1'b0, cfg.nominal_current, 3'b000}
                    + {3'b000, cfg.nominal_current, 1'b0};

    assign dropout_thr = PRODUCT_WIDTH'(cfg.pickup_level) * PRODUCT_WIDTH'(cfg.reset_ratio);
    assign rms_scaled  = {{(PRODUCT_WIDTH-SAMPLE_WIDTH-RATIO_FRAC){1'b0}},
                          rms_sample, {RATIO_FRAC{1'b0}}};

    always_comb begin
        cls.enable        = step_enable;
        cls.in_window     = (rms_x10 > SCALED_WIDTH'(cfg.nominal_current))
                         && (SCALED_WIDTH'(rms_sample) < inom_x10);
        cls.above_level   = rms_sample > cfg.pickup_level;
        cls.below_dropout = rms_scaled < dropout_thr;
    end

endmodule

@@ rtl/dtoc_queue.sv @@
// two-entry queue of classified samples between front and back
module dtoc_queue import dtoc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  class_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output class_t pop_data
);

    class_t     q_mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = count_reg == 2'(QUEUE_DEPTH);
    assign not_empty = count_reg != 2'd0;
    assign pop_data  = q_mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/dtoc_back.sv @@
// back end: hysteresis, off-delay, on-delay, latch and window hold state
module dtoc_back import dtoc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_not_empty,
    input  class_t     q_data,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    logic                    raw_reg, raw_next;
    logic                    pickup_reg, pickup_next;
    logic                    trip_reg, trip_next;
    logic                    latch_reg, latch_next;
    logic                    window_reg, window_next;
    logic [WCOUNT_WIDTH-1:0] wcount_reg, wcount_next;
    logic [COUNT_WIDTH-1:0]  dcount_reg, dcount_next;
    logic [COUNT_WIDTH-1:0]  tcount_reg, tcount_next;
    logic                    m_tvalid_reg;
    logic [7:0]              m_tdata_reg;
    logic [WCOUNT_WIDTH-1:0] wcount_inc;
    logic [COUNT_WIDTH-1:0]  dcount_inc;
    logic [COUNT_WIDTH-1:0]  tcount_inc;
    logic [COUNT_WIDTH-1:0]  dropout_len;
    logic [COUNT_WIDTH-1:0]  trip_len;

    assign q_pop    = q_not_empty && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // zero delay acts as one
    assign dropout_len = (cfg.dropout_samples == '0) ? COUNT_WIDTH'(1) : cfg.dropout_samples;
    assign trip_len    = (cfg.trip_delay_samples == '0) ? COUNT_WIDTH'(1)
                                                        : cfg.trip_delay_samples;
    assign wcount_inc  = wcount_reg + WCOUNT_WIDTH'(1);
    assign dcount_inc  = dcount_reg + COUNT_WIDTH'(1);
    assign tcount_inc  = tcount_reg + COUNT_WIDTH'(1);

    always_comb begin
        raw_next    = raw_reg;
        pickup_next = pickup_reg;
        trip_next   = trip_reg;
        latch_next  = latch_reg;
        window_next = window_reg;
        wcount_next = wcount_reg;
        dcount_next = dcount_reg;
        tcount_next = tcount_reg;
        if (q_data.enable) begin
            // window flag: off-delay of the window test
            if (q_data.in_window) begin
                window_next = 1'b1;
                wcount_next = '0;
            end else if (window_reg) begin
                if (wcount_inc == WCOUNT_WIDTH'(WINDOW_HOLD)) begin
                    window_next = 1'b0;
                    wcount_next = '0;
                end else begin
                    wcount_next = wcount_inc;
                end
            end else begin
                wcount_next = '0;
            end

            // clear wins over set
            if (q_data.above_level && (!cfg.window_mode || window_next)) begin
                raw_next = 1'b1;
            end
            if (q_data.below_dropout) begin
                raw_next = 1'b0;
            end

            if (raw_next) begin
                pickup_next = 1'b1;
                dcount_next = '0;
            end else if (pickup_reg) begin
                if (dcount_inc == dropout_len) begin
                    pickup_next = 1'b0;
                    dcount_next = '0;
                end else begin
                    dcount_next = dcount_inc;
                end
            end else begin
                dcount_next = '0;
            end

            if (!pickup_next) begin
                trip_next   = 1'b0;
                tcount_next = '0;
            end else if (!trip_reg) begin
                if (tcount_inc == trip_len) begin
                    trip_next   = 1'b1;
                    tcount_next = '0;
                end else begin
                    tcount_next = tcount_inc;
                end
            end else begin
                tcount_next = '0;
            end

            if (trip_next) begin
                latch_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg      <= 1'b0;
            pickup_reg   <= 1'b0;
            trip_reg     <= 1'b0;
            latch_reg    <= 1'b0;
            window_reg   <= 1'b0;
            wcount_reg   <= '0;
            dcount_reg   <= '0;
            tcount_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                raw_reg      <= raw_next;
                pickup_reg   <= pickup_next;
                trip_reg     <= trip_next;
                latch_reg    <= latch_next;
                window_reg   <= window_next;
                wcount_reg   <= wcount_next;
                dcount_reg   <= dcount_next;
                tcount_reg   <= tcount_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            m_tdata_reg <= {3'b000, window_next, latch_next, trip_next, pickup_next, raw_next};
        end
    end

    a_trip_latched: assert property (@(posedge aclk) disable iff (!aresetn)
        trip_reg |-> latch_reg)
        else $error("trip without latch");

    a_trip_needs_pickup: assert property (@(posedge aclk) disable iff (!aresetn)
        trip_reg |-> pickup_reg)
        else $error("trip without pickup");

    a_raw_implies_pickup: assert property (@(posedge aclk) disable iff (!aresetn)
        raw_reg |-> pickup_reg)
        else $error("raw pickup without pickup");

    a_disabled_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && !q_data.enable) |=> ($stable(latch_reg) && $stable(dcount_reg)
                                       && $stable(tcount_reg) && $stable(wcount_reg)))
        else $error("state changed on a disabled step");

    a_output_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(q_pop) |-> (m_tdata_reg[4:0]
                          == {window_reg, latch_reg, trip_reg, pickup_reg, raw_reg}))
        else $error("result beat differs from state");

endmodule

@@ rtl/definite_time_overcurrent_element.sv @@
// top level of the definite-time overcurrent element with configuration registers
//
// Takes one RMS sample per beat and returns one beat of five flags per sample, at a
// sustained rate of one sample per clock cycle, set by the back end state update, while
// m_tready is high; a result passes through the queue and the output register to the
// master side. A two-entry queue separates the sample classification (window test,
// pickup and dropout compares) from that state update, and an output register holds a
// result until it is taken. The user must write configuration through the APB port only
// while the element is idle, unenforced by the block; no clearing pass follows reset.
module definite_time_overcurrent_element import dtoc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [23:0] rms_sample
    input  logic                  s_tuser,   // [0] step_enable
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] raw_pickup, [1] pickup, [2] trip,
                                             // [3] trip_latched, [4] window_valid
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t       cfg_reg;
    class_t     front_cls;
    class_t     q_data;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;
    reg_index_t reg_sel;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[ADDR_WIDTH-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign s_tready  = !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pickup_level       <= 24'd16777215;
            cfg_reg.reset_ratio        <= 16'd62259;
            cfg_reg.dropout_samples    <= 24'd1;
            cfg_reg.trip_delay_samples <= 24'd2500;
            cfg_reg.nominal_current    <= 24'd0;
            cfg_reg.window_mode        <= 1'b0;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_PICKUP_LEVEL:    cfg_reg.pickup_level       <= pwdata[SAMPLE_WIDTH-1:0];
                REG_DROPOUT_RATIO:   cfg_reg.reset_ratio        <= pwdata[RATIO_WIDTH-1:0];
                REG_DROPOUT_SAMPLES: cfg_reg.dropout_samples    <= pwdata[COUNT_WIDTH-1:0];
                REG_TRIP_DELAY:      cfg_reg.trip_delay_samples <= pwdata[COUNT_WIDTH-1:0];
                REG_NOMINAL_CURRENT: cfg_reg.nominal_current    <= pwdata[SAMPLE_WIDTH-1:0];
                REG_WINDOW_MODE:     cfg_reg.window_mode        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_PICKUP_LEVEL:    prdata = 32'(cfg_reg.pickup_level);
            REG_DROPOUT_RATIO:   prdata = 32'(cfg_reg.reset_ratio);
            REG_DROPOUT_SAMPLES: prdata = 32'(cfg_reg.dropout_samples);
            REG_TRIP_DELAY:      prdata = 32'(cfg_reg.trip_delay_samples);
            REG_NOMINAL_CURRENT: prdata = 32'(cfg_reg.nominal_current);
            REG_WINDOW_MODE:     prdata = 32'(cfg_reg.window_mode);
            default:             prdata = 32'd0;
        endcase
    end

    dtoc_front u_front (
        .rms_sample  (s_tdata[SAMPLE_WIDTH-1:0]),
        .step_enable (s_tuser),
        .cfg         (cfg_reg),
        .cls         (front_cls)
    );

    dtoc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_tvalid),
        .push_data (front_cls),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    dtoc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
